[design/asmk_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package asmk_pkg;

  typedef enum logic [1:0] {
    REQ_LOAD    = 2'd0,
    REQ_TEXT    = 2'd1,
    REQ_RESTART = 2'd2
  } req_type_t;

  // register word indexes on the configuration port (byte address = 4 * index)
  localparam logic REG_PATTERN_LENGTH  = 1'b0;
  localparam logic REG_MATCH_THRESHOLD = 1'b1;

  localparam int unsigned DIST_MAX = 63;

  typedef struct packed {
    req_type_t   req_type;
    logic [7:0]  char_value;
    logic [4:0]  pattern_index;
  } item_t;

  typedef struct packed {
    logic [31:0] text_position;
    logic [5:0]  distance;
    logic        is_match;
  } result_t;

  // what moves from one cell to the next with each transaction
  typedef struct packed {
    req_type_t   req_type;
    logic [7:0]  char_value;
    logic [4:0]  pattern_index;
    logic [31:0] text_position;
    logic [5:0]  distance;
  } token_t;

endpackage

`default_nettype wire

[design/approx_string_match_k_diff_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// channel   | signals                          | moves
// ----------+----------------------------------+------------------------------------
// item      | item_valid, item_stall, item     | load / text character / restart
// result    | result_valid, result_stall, result | position, distance, match flag
// config    | psel penable pwrite paddr pwdata prdata pready | pattern_length, threshold
//
// one transaction enters per cycle while item_stall is low; it walks the chain of
// MAX_PATTERN registered cells, so a text character gives its result at the tail once
// it has passed every cell; a stall at the tail can hold it on the way.
// reset (rst, synchronous) restores the column in the same cycle; no clearing pass.
// result_stall holds only the tail; empty slots upstream still fill, so new
// transactions are taken until the chain is full. loads and restarts leave no result.

module approx_string_match_k_diff_top #(
  parameter int MAX_PATTERN = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_stall,
  input  wire asmk_pkg::item_t   item,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output asmk_pkg::result_t      result,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int DW = $clog2(MAX_PATTERN + 2);
  localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  logic [5:0]  pattern_length;
  logic [5:0]  match_threshold;
  logic [31:0] position_count;
  logic [IW-1:0] tap_row;

  logic              cell_valid [MAX_PATTERN+1];
  asmk_pkg::token_t  cell_tok   [MAX_PATTERN+1];
  logic [DW-1:0]     cell_above [MAX_PATTERN+1];
  logic [DW-1:0]     cell_diag  [MAX_PATTERN+1];
  logic              cell_hold  [MAX_PATTERN+1];

  logic item_accept;
  logic cfg_write;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length  <= 6'd1;
      match_threshold <= 6'd0;
    end else if (cfg_write) begin
      unique case (paddr[2])
        asmk_pkg::REG_PATTERN_LENGTH:  pattern_length  <= pwdata[5:0];
        asmk_pkg::REG_MATCH_THRESHOLD: match_threshold <= pwdata[5:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      asmk_pkg::REG_PATTERN_LENGTH:  prdata = {26'd0, pattern_length};
      asmk_pkg::REG_MATCH_THRESHOLD: prdata = {26'd0, match_threshold};
      default:                       prdata = 32'd0;
    endcase
  end

  // row whose value is reported
  always_comb begin
    priority if (pattern_length == 6'd0) begin
      tap_row = '0;
    end else if (int'(pattern_length) > MAX_PATTERN) begin
      tap_row = IW'(MAX_PATTERN - 1);
    end else begin
      tap_row = IW'(pattern_length - 6'd1);
    end
  end

  // text position counter
  assign item_stall  = cell_hold[0];
  assign item_accept = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      position_count <= '0;
    end else if (item_accept) begin
      if (item.req_type == asmk_pkg::REQ_RESTART) begin
        position_count <= '0;
      end else if (item.req_type == asmk_pkg::REQ_TEXT && position_count != '1) begin
        position_count <= position_count + 32'd1;
      end
    end
  end

  // head of the chain: row 0 is fixed at zero
  assign cell_valid[0]               = item_valid;
  assign cell_tok[0].req_type        = item.req_type;
  assign cell_tok[0].char_value      = item.char_value;
  assign cell_tok[0].pattern_index   = item.pattern_index;
  assign cell_tok[0].text_position   = position_count;
  assign cell_tok[0].distance        = '0;
  assign cell_above[0]               = '0;
  assign cell_diag[0]                = '0;

  for (genvar r = 0; r < MAX_PATTERN; r++) begin : g_cell
    asmk_cell #(
      .ROW (r),
      .DW  (DW)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .tap        (tap_row == IW'(r)),
      .hold_in    (cell_hold[r+1]),
      .hold_out   (cell_hold[r]),
      .prev_valid (cell_valid[r]),
      .prev_tok   (cell_tok[r]),
      .prev_above (cell_above[r]),
      .prev_diag  (cell_diag[r]),
      .valid      (cell_valid[r+1]),
      .tok        (cell_tok[r+1]),
      .above      (cell_above[r+1]),
      .diag       (cell_diag[r+1])
    );
  end

  // tail: loads and restarts drain without a result
  assign result_valid = cell_valid[MAX_PATTERN]
                        && cell_tok[MAX_PATTERN].req_type == asmk_pkg::REQ_TEXT;
  assign cell_hold[MAX_PATTERN] = result_valid && result_stall;

  assign result.text_position = cell_tok[MAX_PATTERN].text_position;
  assign result.distance      = cell_tok[MAX_PATTERN].distance;
  assign result.is_match      = (cell_tok[MAX_PATTERN].distance <= match_threshold);

  a_restart_clears_count : assert property (@(posedge clk) disable iff (rst)
    item_accept && item.req_type == asmk_pkg::REQ_RESTART |=> position_count == '0)
    else $error("position count not cleared by restart");

  a_text_counts : assert property (@(posedge clk) disable iff (rst)
    item_accept && item.req_type == asmk_pkg::REQ_TEXT && position_count != '1
    |=> position_count == $past(position_count) + 32'd1)
    else $error("position count did not advance on text character");

  a_stall_only_when_full : assert property (@(posedge clk) disable iff (rst)
    item_stall |-> cell_valid[1] && result_valid && result_stall)
    else $error("input stalled with room in the head cell");

  a_hold_keeps_tail : assert property (@(posedge clk) disable iff (rst)
    cell_hold[MAX_PATTERN] |=> cell_valid[MAX_PATTERN]
                               && $stable(cell_tok[MAX_PATTERN].text_position))
    else $error("tail token lost while held");

endmodule

`default_nettype wire

[design/asmk_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module asmk_cell #(
  parameter int ROW = 0,
  parameter int DW  = 6
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            tap,
  input  wire logic            hold_in,
  output logic                 hold_out,
  input  wire logic            prev_valid,
  input  wire asmk_pkg::token_t prev_tok,
  input  wire logic [DW-1:0]   prev_above,
  input  wire logic [DW-1:0]   prev_diag,
  output logic                 valid,
  output asmk_pkg::token_t     tok,
  output logic [DW-1:0]        above,
  output logic [DW-1:0]        diag
);

  logic [DW-1:0] col;
  logic [7:0]    pat;
  logic          load;
  logic [DW:0]   via_left;
  logic [DW:0]   via_above;
  logic [DW:0]   via_diag;
  logic [DW:0]   best;
  logic [DW-1:0] col_new;
  logic [5:0]    dist_clamped;
  asmk_pkg::token_t tok_next;

  // a slot holds only while its occupant cannot move on
  assign hold_out = valid && hold_in;
  assign load     = !hold_out;

  always_comb begin
    via_left  = {1'b0, col} + (DW+1)'(1);
    via_above = {1'b0, prev_above} + (DW+1)'(1);
    via_diag  = {1'b0, prev_diag} + (DW+1)'((pat != prev_tok.char_value) ? 1 : 0);
    best      = (via_left < via_above) ? via_left : via_above;
    if (via_diag < best) begin
      best = via_diag;
    end
    // row r never exceeds r+1, so the top bit is always clear
    col_new = best[DW-1:0];
    if (int'(col_new) > int'(asmk_pkg::DIST_MAX)) begin
      dist_clamped = 6'(asmk_pkg::DIST_MAX);
    end else begin
      dist_clamped = 6'(col_new);
    end
    tok_next = prev_tok;
    if (prev_tok.req_type == asmk_pkg::REQ_TEXT && tap) begin
      tok_next.distance = dist_clamped;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      col   <= DW'(ROW + 1);
    end else if (load) begin
      valid <= prev_valid;
      if (prev_valid) begin
        unique case (prev_tok.req_type)
          asmk_pkg::REQ_TEXT: begin
            col <= col_new;
          end
          asmk_pkg::REQ_RESTART: begin
            col <= DW'(ROW + 1);
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && prev_valid) begin
      tok   <= tok_next;
      above <= col_new;
      diag  <= col;
      if (prev_tok.req_type == asmk_pkg::REQ_LOAD && int'(prev_tok.pattern_index) == ROW) begin
        pat <= prev_tok.char_value;
      end
    end
  end

endmodule

`default_nettype wire

[verif/approx_string_match_k_diff_top_test.sv]
`timescale 1ns / 1ps

module approx_string_match_k_diff_top_test;

  localparam int MAX_PAT = 32;
  localparam int DRAIN_CYCLES = 4 * MAX_PAT;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 550;
  // request code with no meaning, must be ignored
  localparam logic [1:0] REQ_RESERVED = 2'd3;

  logic clk;
  logic rst;
  logic item_valid;
  logic item_stall;
  asmk_pkg::item_t item;
  logic result_valid;
  logic result_stall = 1'b0;
  asmk_pkg::result_t result;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  approx_string_match_k_diff_top uut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // scoreboard copy of the matcher state
  logic [7:0] pattern_copy [MAX_PAT];
  int unsigned column_copy [MAX_PAT];
  logic [31:0] scan_position;
  logic [5:0] length_cfg;
  logic [5:0] threshold_cfg;
  asmk_pkg::result_t pending_results [$];

  int errors = 0;
  int unsigned cycle_count = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  asmk_pkg::result_t due_result;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    result_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: position %0d distance %0d match %0b",
               result.text_position, result.distance, result.is_match);
        errors++;
      end else begin
        due_result = pending_results.pop_front();
        if (result.text_position !== due_result.text_position) begin
          $error("text_position: expected %0d, got %0d",
                 due_result.text_position, result.text_position);
          errors++;
        end
        if (result.distance !== due_result.distance) begin
          $error("distance: expected %0d, got %0d", due_result.distance, result.distance);
          errors++;
        end
        if (result.is_match !== due_result.is_match) begin
          $error("is_match: expected %0b, got %0b", due_result.is_match, result.is_match);
          errors++;
        end
      end
    end
  end

  task automatic reset_column();
    for (int r = 0; r < MAX_PAT; r++) column_copy[r] = r + 1;
    scan_position = '0;
  endtask

  // one text byte: sweep every row of the column, report the row at the pattern length
  task automatic advance_column(input logic [7:0] ch);
    int unsigned diag;
    int unsigned above_v;
    int unsigned old_v;
    int unsigned cand;
    int unsigned eff_len;
    int unsigned dist_v;
    asmk_pkg::result_t res;
    diag = 0;
    above_v = 0;
    for (int r = 0; r < MAX_PAT; r++) begin
      old_v = column_copy[r];
      cand = old_v + 1;
      if (above_v + 1 < cand) cand = above_v + 1;
      if (diag + ((pattern_copy[r] != ch) ? 1 : 0) < cand)
        cand = diag + ((pattern_copy[r] != ch) ? 1 : 0);
      column_copy[r] = cand;
      diag = old_v;
      above_v = cand;
    end
    eff_len = length_cfg;
    if (eff_len == 0) eff_len = 1;
    if (eff_len > MAX_PAT) eff_len = MAX_PAT;
    dist_v = column_copy[eff_len - 1];
    if (dist_v > asmk_pkg::DIST_MAX) dist_v = asmk_pkg::DIST_MAX;
    res.text_position = scan_position;
    res.distance = dist_v[5:0];
    res.is_match = (dist_v <= threshold_cfg);
    pending_results.push_back(res);
    if (scan_position != 32'hFFFF_FFFF) scan_position = scan_position + 1;
  endtask

  task automatic send_item(input asmk_pkg::item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (item_stall);
    case (it.req_type)
      asmk_pkg::REQ_LOAD: pattern_copy[it.pattern_index] = it.char_value;
      asmk_pkg::REQ_TEXT: advance_column(it.char_value);
      asmk_pkg::REQ_RESTART: reset_column();
      default: ;
    endcase
  endtask

  task automatic send_fields(input logic [1:0] req, input logic [7:0] ch,
                             input logic [4:0] idx);
    asmk_pkg::item_t it;
    it.req_type = asmk_pkg::req_type_t'(req);
    it.char_value = ch;
    it.pattern_index = idx;
    send_item(it);
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write, then read back the low six bits
  task automatic config_write(input logic reg_idx, input logic [5:0] value);
    logic [31:0] word;
    word = $urandom();
    word[5:0] = value;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_idx, 2'b00};
    pwdata <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (reg_idx == asmk_pkg::REG_PATTERN_LENGTH) length_cfg = value;
    else threshold_cfg = value;
    @(posedge clk);
    psel <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[5:0] !== value) begin
      $error("register %0d readback: expected %0d, got %0d", reg_idx, value, prdata[5:0]);
      errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [5:0] len, input logic [5:0] thr);
    wait_drained();
    config_write(asmk_pkg::REG_PATTERN_LENGTH, len);
    config_write(asmk_pkg::REG_MATCH_THRESHOLD, thr);
  endtask

  function automatic logic [7:0] random_base();
    case ($urandom_range(0, 3))
      0: return 8'h61;
      1: return 8'h63;
      2: return 8'h67;
      default: return 8'h74;
    endcase
  endfunction

  // every slot is written before any text, so no unwritten entry is ever read
  task automatic test_pattern_load();
    send_fields(asmk_pkg::REQ_LOAD, 8'h00, 5'd0);
    for (int i = 1; i < MAX_PAT - 1; i++) send_fields(asmk_pkg::REQ_LOAD, random_base(), i[4:0]);
    send_fields(asmk_pkg::REQ_LOAD, 8'hFF, 5'd31);
  endtask

  task automatic test_default_config();
    send_fields(asmk_pkg::REQ_TEXT, 8'h00, 5'd31);
    send_fields(asmk_pkg::REQ_TEXT, 8'hFF, 5'd0);
    send_fields(REQ_RESERVED, 8'hFF, 5'd31);
    send_fields(asmk_pkg::REQ_RESTART, 8'h5A, 5'd10);
    send_fields(asmk_pkg::REQ_TEXT, 8'h00, 5'd0);
  endtask

  task automatic test_config_extremes();
    set_config(6'd0, 6'd0);
    send_fields(asmk_pkg::REQ_TEXT, 8'h00, 5'd0);
    send_fields(asmk_pkg::REQ_TEXT, 8'h61, 5'd0);
    set_config(6'd63, 6'd63);
    send_fields(asmk_pkg::REQ_TEXT, 8'h61, 5'd0);
    send_fields(asmk_pkg::REQ_TEXT, 8'hFF, 5'd0);
    set_config(6'd32, 6'd32);
    send_fields(asmk_pkg::REQ_RESTART, 8'h00, 5'd0);
    for (int i = 0; i < 4; i++) send_fields(asmk_pkg::REQ_TEXT, pattern_copy[i], 5'd0);
    set_config(6'd4, 6'd1);
    send_fields(asmk_pkg::REQ_RESTART, 8'h00, 5'd0);
    for (int i = 0; i < 4; i++) send_fields(asmk_pkg::REQ_TEXT, pattern_copy[i], 5'd0);
  endtask

  // mostly text that follows the pattern with edits, plus reloads, restarts and junk
  task automatic random_scan(input int n_items);
    int sent;
    int cursor;
    int roll;
    int eff_len;
    asmk_pkg::item_t it;
    sent = 0;
    cursor = 0;
    while (sent < n_items) begin
      roll = $urandom_range(0, 99);
      it.char_value = 8'($urandom_range(0, 255));
      it.pattern_index = 5'($urandom_range(0, MAX_PAT - 1));
      eff_len = (length_cfg == 0) ? 1 : (length_cfg > MAX_PAT) ? MAX_PAT : length_cfg;
      if (roll < 2) begin
        it.req_type = asmk_pkg::req_type_t'(REQ_RESERVED);
        send_item(it);
      end else begin
        if (roll < 5) begin
          it.req_type = asmk_pkg::REQ_RESTART;
          cursor = 0;
        end else if (roll < 9) begin
          it.req_type = asmk_pkg::REQ_LOAD;
          if ($urandom_range(0, 3) != 0) it.char_value = random_base();
        end else begin
          it.req_type = asmk_pkg::REQ_TEXT;
          if ($urandom_range(0, 99) < 75) begin
            it.char_value = pattern_copy[cursor % eff_len];
            if ($urandom_range(0, 9) == 0) it.char_value = random_base();
            if ($urandom_range(0, 19) != 0) cursor++;
          end else if ($urandom_range(0, 9) != 0) begin
            it.char_value = random_base();
          end
          if ($urandom_range(0, 29) == 0) cursor = 0;
        end
        send_item(it);
        sent++;
      end
    end
  endtask

  task automatic test_back_pressure();
    send_idle_pct = 12;
    stall_pct = 75;
    set_config(6'($urandom_range(1, 12)), 6'($urandom_range(0, 3)));
    random_scan(PHASE_ITEMS);
  endtask

  task automatic test_sparse_sender();
    send_idle_pct = 75;
    stall_pct = 12;
    set_config(6'd32, 6'($urandom_range(0, 40)));
    random_scan(PHASE_ITEMS);
  endtask

  task automatic test_full_throughput();
    send_idle_pct = 0;
    stall_pct = 0;
    set_config(6'($urandom_range(1, 20)), 6'($urandom_range(0, 6)));
    random_scan(PHASE_ITEMS / 2);
    set_config(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
    random_scan(PHASE_ITEMS / 2);
  endtask

  initial begin
    rst <= 1'b1;
    item_valid <= 1'b0;
    item <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    for (int r = 0; r < MAX_PAT; r++) pattern_copy[r] = 8'h00;
    reset_column();
    length_cfg = 6'd1;
    threshold_cfg = 6'd0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_pattern_load();
    test_default_config();
    test_config_extremes();
    test_back_pressure();
    test_sparse_sender();
    test_full_throughput();
    wait_drained();

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
